FILE: rtl/edd_pkg.sv
// shared types and constants of the escaped delta index decoder
`default_nettype none

package edd_pkg;

  localparam logic [7:0] ESCAPE_CODE = 8'd126;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned INDEX_BITS = 16;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_DELTA = 2'd1,
    PH_HIGH  = 2'd2,
    PH_LOW   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] prev_index;
    phase_t                phase;
    logic [BYTE_BITS-1:0]  held_high;
    logic [INDEX_BITS-1:0] emitted;
  } dec_state_t;

endpackage

`default_nettype wire

FILE: rtl/edd_step.sv
// one decode step: next decoder state and the optional index for one code byte
`default_nettype none

module edd_step (
  input  edd_pkg::dec_state_t cur,
  input  logic [7:0]          code,
  input  logic [15:0]         count,
  output edd_pkg::dec_state_t nxt,
  output logic                emit,
  output logic [15:0]         value,
  output logic                last
);
  import edd_pkg::*;

  logic [15:0] sext;
  logic [15:0] base;
  logic [16:0] n;

  assign sext = {{8{code[7]}}, code};

  always_comb begin
    nxt   = cur;
    emit  = 1'b0;
    value = sext;
    case (cur.phase)
      PH_FIRST: begin
        emit  = 1'b1;
        value = sext;
      end
      PH_DELTA: begin
        if (code == ESCAPE_CODE) begin
          nxt.phase = PH_HIGH;
        end else begin
          emit  = 1'b1;
          value = cur.prev_index + sext;
        end
      end
      PH_HIGH: begin
        nxt.held_high = code;
        nxt.phase     = PH_LOW;
      end
      PH_LOW: begin
        emit  = 1'b1;
        value = cur.prev_index + {cur.held_high, code};
      end
      default: begin
        nxt.phase = PH_FIRST;
      end
    endcase

    // count of indices emitted so far, restarted by a first byte
    base = (cur.phase == PH_FIRST) ? 16'd0 : cur.emitted;
    n    = {1'b0, base} + 17'd1;
    last = emit && (n >= {1'b0, count});

    if (emit) begin
      nxt.prev_index = value;
      if (last) begin
        nxt.emitted = 16'd0;
        nxt.phase   = PH_FIRST;
      end else begin
        nxt.emitted = n[15:0];
        nxt.phase   = PH_DELTA;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/escaped_delta_index_decoder_unit.sv
// top level of the escaped delta index decoder
//
//  channel   dir  payload (low bit up)           transfer when
//  s_*       in   tdata[7:0] code_byte           s_tvalid && s_tready
//  m_*       out  tdata[15:0] index_value, tlast m_tvalid && m_tready
//  cfg_*     in   wr_data[15:0] index_count      cfg_wr_en
//
// one code byte per cycle sustained while m_* is not stalled; a byte that
// yields an index reaches m_* via the input register and the result register
// the decoder state updates as a byte leaves the input register, so bytes
// follow each other with no gap
// rst is synchronous: phase back to first literal, index_count to 1
// a stalled result holds; the input register still takes a byte while the
// result waits, then s_tready drops until the result is taken
`default_nettype none

module escaped_delta_index_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  // code_byte
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // index_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  // last_index
  output logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import edd_pkg::*;

  // index count register
  logic [15:0] index_count;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // decoder state
  dec_state_t state;
  dec_state_t state_next;

  // step outputs
  logic        step_emit;
  logic [15:0] step_value;
  logic        step_last;

  // result register
  logic        out_valid;
  logic [15:0] out_value;
  logic        out_last;

  logic advance;

  // the input register moves on when the result register is free or drains
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  edd_step u_step (
    .cur   (state),
    .code  (in_byte),
    .count (index_count),
    .nxt   (state_next),
    .emit  (step_emit),
    .value (step_value),
    .last  (step_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      index_count <= 16'd1;
    end else if (cfg_wr_en) begin
      index_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.prev_index <= 16'd0;
      state.phase      <= PH_FIRST;
      state.held_high  <= 8'd0;
      state.emitted    <= 16'd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      // escape and high bytes leave the result register empty
      out_valid <= step_emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_emit) begin
      out_value <= step_value;
      out_last  <= step_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

FILE: rtl/edd_checker.sv
// port-level checks of the escaped delta index decoder and their bind
`default_nettype none

module edd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // input back-pressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a stalled result");

  // a fresh result comes from a byte taken in through the input register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && !rst, 2))
    else $error("result without a matching input transfer");

endmodule

bind escaped_delta_index_decoder_unit edd_checker u_edd_checker (
  .clk         (clk),
  .rst         (rst),
  .s_tvalid    (s_tvalid),
  .s_tready    (s_tready),
  .m_tvalid    (m_tvalid),
  .m_tready    (m_tready),
  .m_tdata     (m_tdata),
  .m_tlast     (m_tlast)
);

`default_nettype wire

FILE: sim/tb_top.sv
// self-checking testbench of the escaped delta index decoder: directed table, then random meshes
`default_nettype none

module tb_top;
  import edd_pkg::*;

  localparam int LATENCY     = 2;
  localparam int SETTLE      = LATENCY + 3;   // covers an escape byte still in flight
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_CODES = 400;

  typedef enum logic {ROW_CODE, ROW_COUNT} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] arg;        // code byte in the low bits, or a new index_count
    logic        typed;      // expected index written out below
    logic [15:0] want_value;
    logic        want_last;
  } plan_row_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] value;
    logic                  last;
  } index_t;

  // directed plan: typed rows are read straight off the decoding rules
  localparam plan_row_t PLAN [28] = '{
    // reset count is 1, so every byte is a lone literal marked last
    '{ROW_CODE,  16'h0000, 1'b1, 16'h0000, 1'b1},
    '{ROW_CODE,  16'h007F, 1'b1, 16'h007F, 1'b1},
    '{ROW_CODE,  16'h0080, 1'b1, 16'hFF80, 1'b1},
    '{ROW_CODE,  16'h00FF, 1'b1, 16'hFFFF, 1'b1},
    // escape value as first byte is just a literal
    '{ROW_CODE,  16'h007E, 1'b1, 16'h007E, 1'b1},
    // count of zero acts like one
    '{ROW_COUNT, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h0005, 1'b1, 16'h0005, 1'b1},
    // longest mesh: deltas at the extremes and escapes
    '{ROW_COUNT, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h0010, 1'b1, 16'h0010, 1'b0},
    '{ROW_CODE,  16'h007F, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h0080, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h00FF, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h007E, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h007E, 1'b0, 16'h0000, 1'b0},   // high byte equal to escape is data
    '{ROW_CODE,  16'h00FF, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h007E, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h00FF, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h00FF, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h007E, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h0080, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h0000, 1'b0, 16'h0000, 1'b0},
    // count lowered below what is already emitted: next index ends the mesh
    '{ROW_COUNT, 16'h0003, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h00F3, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h0002, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h007E, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h0001, 1'b0, 16'h0000, 1'b0},
    '{ROW_CODE,  16'h007F, 1'b0, 16'h0000, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  // decoder shadow state
  phase_t                dec_phase = PH_FIRST;
  logic [INDEX_BITS-1:0] prev_index = '0;
  logic [BYTE_BITS-1:0]  held_high = '0;
  logic [INDEX_BITS-1:0] emitted = '0;
  logic [INDEX_BITS-1:0] index_count = 16'd1;

  index_t pending_idx [$];
  index_t head;
  int     errors = 0;
  int     cycles = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  logic   hold_req = 1'b0;
  logic   hold_seen = 1'b0;
  int     hold_left = 0;

  escaped_delta_index_decoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
    errors++;
  endtask

  // advance the shadow decoder by one code byte
  task automatic decode_byte(input logic [7:0] code, output bit made, output index_t idx);
    logic [INDEX_BITS-1:0] sum;
    made = 1'b0;
    sum  = '0;
    case (dec_phase)
      PH_FIRST: begin
        emitted = '0;
        made = 1'b1;
        sum = {{8{code[7]}}, code};
      end
      PH_DELTA: begin
        if (code == ESCAPE_CODE) begin
          dec_phase = PH_HIGH;
        end else begin
          made = 1'b1;
          sum = prev_index + {{8{code[7]}}, code};
        end
      end
      PH_HIGH: begin
        held_high = code;
        dec_phase = PH_LOW;
      end
      default: begin
        made = 1'b1;
        sum = prev_index + {held_high, code};
      end
    endcase
    idx.value = sum;
    idx.last  = 1'b0;
    if (made) begin
      prev_index = sum;
      idx.last = ({1'b0, emitted} + 17'd1) >= {1'b0, index_count};
      if (idx.last) begin
        emitted = '0;
        dec_phase = PH_FIRST;
      end else begin
        emitted = emitted + 16'd1;
        dec_phase = PH_DELTA;
      end
    end
  endtask

  // offer one byte, wait for its transfer, then log what it should produce
  task automatic send_code(input logic [7:0] code, input bit typed,
                           input logic [15:0] want_value, input bit want_last);
    bit     made;
    index_t idx;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    do @(posedge clk); while (!s_tready);
    decode_byte(code, made, idx);
    if (typed) begin
      idx.value = want_value;
      idx.last  = want_last;
    end
    if (made || typed) pending_idx.push_back(idx);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_idx.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(input logic [15:0] count);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    index_count = count;
  endtask

  // receiver: check each result transfer, then pick the next tready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_idx.size() == 0) begin
        report_mismatch("unexpected index", m_tdata, 16'd0);
      end else begin
        head = pending_idx.pop_front();
        if (m_tdata !== head.value) report_mismatch("index_value", m_tdata, head.value);
        if (m_tlast !== head.last) report_mismatch("last_index", {15'd0, m_tlast},
                                                   {15'd0, head.last});
      end
    end
    m_tready <= (hold_left != 0) ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // long receiver hold-off, started by a toggle of hold_req
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin
    int          sent;
    int          units;
    int          pick;
    logic [15:0] count;
    logic [7:0]  code;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_COUNT)
        write_count(PLAN[i].arg);
      else
        send_code(PLAN[i].arg[7:0], PLAN[i].typed, PLAN[i].want_value, PLAN[i].want_last);
    end

    // three idling profiles; the last one has none and carries the hold-off
    for (int seg = 0; seg < 3; seg++) begin
      send_idle_pct <= (seg == 0) ? 32 : (seg == 1) ? 61 : 0;
      recv_idle_pct <= (seg == 0) ? 61 : (seg == 1) ? 32 : 0;
      sent = 0;
      while (sent < RANDOM_CODES / 3) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)      count = 16'd0;
        else if (pick == 1) count = 16'hFFFF;
        else if (pick == 2) count = 16'($urandom_range(1, 65535));
        else                count = 16'($urandom_range(1, 8));
        // the write lands wherever the decoder is, often mid-mesh
        write_count(count);
        units = $urandom_range(1, 14);
        if (seg == 2 && sent == 0) begin
          hold_req <= ~hold_req;
          units = 24;
        end
        for (int u = 0; u < units; u++) begin
          pick = $urandom_range(0, 99);
          if (pick < 5) begin
            // noise: any byte in any phase
            send_code(8'($urandom_range(0, 255)), 1'b0, 16'd0, 1'b0);
            sent++;
          end else if (dec_phase == PH_DELTA && pick < 30) begin
            send_code(ESCAPE_CODE, 1'b0, 16'd0, 1'b0);
            send_code(8'($urandom_range(0, 255)), 1'b0, 16'd0, 1'b0);
            send_code(8'($urandom_range(0, 255)), 1'b0, 16'd0, 1'b0);
            sent += 3;
          end else begin
            code = 8'($urandom_range(0, 255));
            if (dec_phase == PH_DELTA && code == ESCAPE_CODE) code = 8'h7D;
            send_code(code, 1'b0, 16'd0, 1'b0);
            sent++;
          end
        end
      end
    end

    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
